>>> rtl/rdi_pkg.sv
// Package for the indexed ring deque: request kinds and default sizes.
// No dependencies; used by rdi_store and ring_deque_indexed_unit.
`default_nettype none

package rdi_pkg;

	// Default storage sizes
	localparam int DEF_CAPACITY   = 1024;
	localparam int DEF_WORD_WIDTH = 32;

	// Fixed port widths
	localparam int KIND_W   = 3;
	localparam int POS_W    = 10;
	localparam int IO_WORD_W = 32;
	localparam int COUNT_W  = 11;

	// Request kinds; codes 6 and 7 are ignored
	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH_BACK  = 3'd0,
		KIND_POP_BACK   = 3'd1,
		KIND_PUSH_FRONT = 3'd2,
		KIND_POP_FRONT  = 3'd3,
		KIND_SET        = 3'd4,
		KIND_GET        = 3'd5
	} kind_t;

endpackage

`default_nettype wire

>>> rtl/rdi_store.sv
// Ring store of the deque: one single-port synchronous memory, read data
// registered, plus the zero-fill sweep after reset. Depends on rdi_pkg.
`default_nettype none

module rdi_store #(
	parameter int CAPACITY   = rdi_pkg::DEF_CAPACITY,
	parameter int WORD_WIDTH = rdi_pkg::DEF_WORD_WIDTH,
	localparam int PW = $clog2(CAPACITY)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  we,
	input  wire logic [PW-1:0]         addr,
	input  wire logic [WORD_WIDTH-1:0] wdata,
	output logic      [WORD_WIDTH-1:0] rdata,
	output logic                       clearing
);

	logic [WORD_WIDTH-1:0] mem [CAPACITY];
	logic [PW-1:0]         clr_q;
	logic                  clr_busy_q;
	logic [WORD_WIDTH-1:0] rdata_q;

	// Zero-fill sweep, one entry per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			if (clr_q == PW'(CAPACITY - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_q <= clr_q + PW'(1);
		end
	end

	// Memory write port: sweep has priority (caller is held off meanwhile)
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_q] <= '0;
		end else if (en && we) begin
			mem[addr] <= wdata;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (en && !we) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata    = rdata_q;
	assign clearing = clr_busy_q;

endmodule

`default_nettype wire

>>> rtl/ring_deque_indexed_unit.sv
// Indexed ring deque, top level: request decode, head/count registers,
// result stage. Depends on rdi_pkg and rdi_store.
//
//   port group                  dir  meaning
//   start/busy                  in   request transfer when start && !busy
//   kind, position, word_in     in   request payload
//   done                        out  result strobe, one cycle, no back-pressure
//   ok, word_out, count         out  result payload, valid while done is high
//
// A request is accepted when start && !busy; its result appears in the cycle
// right after, so one request per cycle is sustained while busy is low. Each
// successful request makes a single access to the ring memory, whose read is registered.
// After reset, busy stays high while the memory is zero-filled. The receiver
// cannot stall; results are never held.
`default_nettype none

module ring_deque_indexed_unit #(
	parameter int CAPACITY   = rdi_pkg::DEF_CAPACITY,
	parameter int WORD_WIDTH = rdi_pkg::DEF_WORD_WIDTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [rdi_pkg::KIND_W-1:0]   kind,
	input  wire logic [rdi_pkg::POS_W-1:0]    position,
	input  wire logic [rdi_pkg::IO_WORD_W-1:0] word_in,
	output logic                              done,
	output logic                              ok,
	output logic [rdi_pkg::IO_WORD_W-1:0]     word_out,
	output logic [rdi_pkg::COUNT_W-1:0]       count
);

	localparam int PW    = $clog2(CAPACITY);
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int OW    = (CW > rdi_pkg::POS_W) ? CW : rdi_pkg::POS_W;
	localparam int SW    = OW + 1;
	localparam int OUT_W = rdi_pkg::IO_WORD_W;
	localparam int CNT_W = rdi_pkg::COUNT_W;

	logic [PW-1:0]         head_q;
	logic [CW-1:0]         cnt_q;
	logic                  done_s1;
	logic                  ok_s1;
	logic                  rd_s1;

	logic                  acc;
	logic                  clearing;
	rdi_pkg::kind_t        kind_c;
	logic                  full;
	logic                  empty;
	logic [OW-1:0]         pos_ext;
	logic [OW-1:0]         offs;
	logic [SW-1:0]         sum;
	logic [SW-1:0]         sum_wrap;
	logic [PW-1:0]         slot;
	logic [PW-1:0]         head_prev;
	logic [PW-1:0]         head_next;
	logic                  mem_en;
	logic                  mem_we;
	logic [PW-1:0]         mem_addr;
	logic [WORD_WIDTH-1:0] mem_wdata;
	logic [WORD_WIDTH-1:0] mem_rdata;
	logic                  ok_c;
	logic                  rd_c;
	logic [CW-1:0]         cnt_d;
	logic [PW-1:0]         head_d;

	assign busy    = clearing;
	assign acc     = start && !clearing;
	assign kind_c  = rdi_pkg::kind_t'(kind);
	assign full    = (cnt_q == CW'(CAPACITY));
	assign empty   = (cnt_q == '0);
	assign pos_ext = OW'(position);

	// Logical offset to ring slot: one add, one conditional subtract
	always_comb begin
		if (kind_c == rdi_pkg::KIND_PUSH_BACK) begin
			offs = OW'(cnt_q);
		end else if (kind_c == rdi_pkg::KIND_POP_BACK) begin
			offs = OW'(cnt_q) - OW'(1);
		end else begin
			offs = pos_ext;
		end
		sum      = SW'(head_q) + SW'(offs);
		sum_wrap = (sum >= SW'(CAPACITY)) ? (sum - SW'(CAPACITY)) : sum;
		slot     = sum_wrap[PW-1:0];
	end

	assign head_prev = (head_q == '0) ? PW'(CAPACITY - 1) : (head_q - PW'(1));
	assign head_next = (head_q == PW'(CAPACITY - 1)) ? '0 : (head_q + PW'(1));
	assign mem_wdata = WORD_WIDTH'(word_in);

	// Request decode: success, memory access, next head and count
	always_comb begin
		ok_c     = 1'b0;
		rd_c     = 1'b0;
		mem_we   = 1'b0;
		mem_addr = slot;
		cnt_d    = cnt_q;
		head_d   = head_q;
		unique case (kind_c)
			rdi_pkg::KIND_PUSH_BACK: begin
				if (!full) begin
					ok_c   = 1'b1;
					mem_we = 1'b1;
					cnt_d  = cnt_q + CW'(1);
				end
			end
			rdi_pkg::KIND_POP_BACK: begin
				if (!empty) begin
					ok_c  = 1'b1;
					rd_c  = 1'b1;
					cnt_d = cnt_q - CW'(1);
				end
			end
			rdi_pkg::KIND_PUSH_FRONT: begin
				mem_addr = head_prev;
				if (!full) begin
					ok_c   = 1'b1;
					mem_we = 1'b1;
					head_d = head_prev;
					cnt_d  = cnt_q + CW'(1);
				end
			end
			rdi_pkg::KIND_POP_FRONT: begin
				mem_addr = head_q;
				if (!empty) begin
					ok_c   = 1'b1;
					rd_c   = 1'b1;
					head_d = head_next;
					cnt_d  = cnt_q - CW'(1);
				end
			end
			rdi_pkg::KIND_SET: begin
				if (pos_ext < OW'(CAPACITY)) begin
					ok_c   = 1'b1;
					mem_we = 1'b1;
					if (pos_ext >= OW'(cnt_q)) begin
						cnt_d = CW'(pos_ext + OW'(1));
					end
				end
			end
			rdi_pkg::KIND_GET: begin
				if (pos_ext < OW'(cnt_q)) begin
					ok_c = 1'b1;
					rd_c = 1'b1;
				end
			end
			default: begin
			end
		endcase
		mem_en = acc && ok_c;
	end

	// Head and count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else if (acc) begin
			head_q <= head_d;
			cnt_q  <= cnt_d;
		end
	end

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
			ok_s1   <= 1'b0;
			rd_s1   <= 1'b0;
		end else begin
			done_s1 <= acc;
			ok_s1   <= acc && ok_c;
			rd_s1   <= acc && rd_c;
		end
	end

	rdi_store #(
		.CAPACITY  (CAPACITY),
		.WORD_WIDTH(WORD_WIDTH)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (mem_en),
		.we      (mem_we),
		.addr    (mem_addr),
		.wdata   (mem_wdata),
		.rdata   (mem_rdata),
		.clearing(clearing)
	);

	// Count register already holds the post-request value in the result cycle
	assign done     = done_s1;
	assign ok       = ok_s1;
	assign word_out = rd_s1 ? OUT_W'(mem_rdata) : '0;
	assign count    = CNT_W'(cnt_q);

	// Checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= PW'(CAPACITY - 1))
		else $error("head pointer out of ring");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> done)
		else $error("accepted request gave no result");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !empty && (kind_c == rdi_pkg::KIND_POP_BACK
			|| kind_c == rdi_pkg::KIND_POP_FRONT))
		|=> (cnt_q == $past(cnt_q) - CW'(1)) && ok)
		else $error("pop did not shrink count");

	a_no_access_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !mem_en)
		else $error("memory access during zero fill");

endmodule

`default_nettype wire
